FILE: rtl/variable_width_glyph_blitter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph blitter
// Clocked on clk, held off while rst is high, in the module that includes it.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_GLYPH_BLITTER_ASSERT_SVH
`define VARIABLE_WIDTH_GLYPH_BLITTER_ASSERT_SVH

// same-cycle implication
`define VWGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vwgb_pkg.sv
// ---------------------------------------------------------------------------
// vwgb_pkg
// Types and fixed constants of the glyph blitter.
// ---------------------------------------------------------------------------
package vwgb_pkg;

  // operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int TILE_BYTES = 16;   // 8 rows x 2 planes
  localparam int GLYPH_ROWS = 8;
  localparam int EA_W       = 11;   // widest byte address a draw can form

  localparam logic [3:0] MAX_WIDTH = 4'd8;
  localparam logic [4:0] F_BASE    = 5'd17;
  localparam logic [3:0] STEP_LAST = 4'd15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ,
    ST_DONE
  } vwgb_state_t;

endpackage

FILE: rtl/vwgb_ram.sv
// ---------------------------------------------------------------------------
// vwgb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module vwgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/variable_width_glyph_blitter.sv
// ---------------------------------------------------------------------------
// variable_width_glyph_blitter
// Blits one variable-width 8-row glyph into plane 0 of a line of 2bpp
// planar 8x8 tiles held in an internal byte store; also reads back bytes.
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid / in_stall| operation, glyph_width, glyph_row_0..7,
//          |                    | pen_x, read_addr
//  out     | out_valid/out_stall| next_x, read_data
//
//  Draw: accept, then each plane-0 byte of the glyph's tile and the next is
//    read and written back, then the result; the single read/write port pair
//    of the tile store sets the pace, one byte per cycle with read and write-back overlapped.
//  Read: accept, store read, result.
//  Reset: the store is swept to zero, all LINE_TILES*16 bytes (1024 by
//    default), with in_stall high throughout.
//  A stalled result sits in the output register; the next item may be taken
//    meanwhile and finishes once the register is free.
// ---------------------------------------------------------------------------
module variable_width_glyph_blitter #(
  parameter int LINE_TILES = 64
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [3:0] glyph_width,
  input  logic [7:0] glyph_row_0,
  input  logic [7:0] glyph_row_1,
  input  logic [7:0] glyph_row_2,
  input  logic [7:0] glyph_row_3,
  input  logic [7:0] glyph_row_4,
  input  logic [7:0] glyph_row_5,
  input  logic [7:0] glyph_row_6,
  input  logic [7:0] glyph_row_7,
  input  logic [8:0] pen_x,
  input  logic [9:0] read_addr,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] next_x,
  output logic [7:0] read_data
);

  `include "variable_width_glyph_blitter_assert.svh"

  localparam int STORE_BYTES = LINE_TILES * vwgb_pkg::TILE_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_BYTES - 1);

  vwgb_pkg::vwgb_state_t state, state_next;

  // latched item
  logic       cur_op;
  logic [3:0] width;
  logic [4:0] shamt;           // f = 17 - w - (x mod 8), 2..17
  logic [15:0] keep_word;
  logic [7:0] rows [vwgb_pkg::GLYPH_ROWS];
  logic [8:0] pen;
  logic [9:0] rd_addr_hold;
  logic       rd_in_range;
  logic [3:0] step;

  // write-back stage of the read-modify-write
  logic              wb_pend;
  logic              wb_ok;
  logic [ADDR_W-1:0] wb_addr;
  logic [7:0]        wb_keep;
  logic [7:0]        wb_set;

  logic [ADDR_W-1:0] clr_cnt;

  // store ports
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  // FSM outputs
  logic accept, out_load, clr_run;

  // ---- accept-time decode ----
  logic [3:0]  w_sat;
  logic [8:0]  w_ones;
  logic [15:0] keep_calc;

  always_comb begin
    w_sat     = (glyph_width > vwgb_pkg::MAX_WIDTH) ? vwgb_pkg::MAX_WIDTH : glyph_width;
    w_ones    = 9'((10'd1 << w_sat) - 10'd1);
    keep_calc = ~16'((25'(w_ones)) << (vwgb_pkg::F_BASE - 5'(w_sat) - 5'(pen_x[2:0])));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op       <= operation;
      width        <= w_sat;
      shamt        <= vwgb_pkg::F_BASE - 5'(w_sat) - 5'(pen_x[2:0]);
      keep_word    <= keep_calc;
      pen          <= pen_x;
      rd_addr_hold <= read_addr;
      rd_in_range  <= 32'(read_addr) < STORE_BYTES;
      rows[0]      <= glyph_row_0;
      rows[1]      <= glyph_row_1;
      rows[2]      <= glyph_row_2;
      rows[3]      <= glyph_row_3;
      rows[4]      <= glyph_row_4;
      rows[5]      <= glyph_row_5;
      rows[6]      <= glyph_row_6;
      rows[7]      <= glyph_row_7;
    end
  end

  // ---- per-byte address and merge terms ----
  // step[3:1] is the row, step[0] picks the glyph's tile (high half of the
  // shifted word) or the following tile (low half).
  logic [6:0]                  tile;
  logic [vwgb_pkg::EA_W-1:0]   byte_ea;
  logic                        byte_ok;
  logic [15:0]                 shifted;

  always_comb begin
    tile    = {1'b0, pen[8:3]} + 7'(step[0]);
    byte_ea = {tile, step[3:1], 1'b0};
    byte_ok = 32'(byte_ea) < STORE_BYTES;
    shifted = 16'(25'(rows[step[3:1]]) << shamt);
  end

  // The 16 bytes of a draw are all distinct and items run one at a time,
  // so a read never meets a pending write to the same byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_pend <= 1'b0;
    end else begin
      wb_pend <= (state == vwgb_pkg::ST_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (state == vwgb_pkg::ST_DRAW) begin
      wb_ok   <= byte_ok;
      wb_addr <= ADDR_W'(byte_ea);
      wb_keep <= step[0] ? keep_word[7:0] : keep_word[15:8];
      wb_set  <= step[0] ? shifted[7:0]   : shifted[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (accept) begin
      step <= '0;
    end else if (state == vwgb_pkg::ST_DRAW) begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clr_run) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // ---- store ports ----
  always_comb begin
    if (clr_run) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 8'h00;
    end else begin
      wr_en   = wb_pend && wb_ok;
      wr_addr = wb_addr;
      wr_data = (rd_data & wb_keep) | wb_set;
    end
    rd_en   = (state == vwgb_pkg::ST_DRAW) || (state == vwgb_pkg::ST_READ);
    rd_addr = (state == vwgb_pkg::ST_READ) ? ADDR_W'(rd_addr_hold) : ADDR_W'(byte_ea);
  end

  vwgb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vwgb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vwgb_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = vwgb_pkg::ST_IDLE;
      end
      vwgb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (operation == vwgb_pkg::OP_READ) ? vwgb_pkg::ST_READ
                                                        : vwgb_pkg::ST_DRAW;
        end
      end
      vwgb_pkg::ST_DRAW: begin
        if (step == vwgb_pkg::STEP_LAST) state_next = vwgb_pkg::ST_DONE;
      end
      vwgb_pkg::ST_READ: begin
        state_next = vwgb_pkg::ST_DONE;
      end
      vwgb_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = vwgb_pkg::ST_IDLE;
      end
      default: begin
        state_next = vwgb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    clr_run  = 1'b0;
    out_load = 1'b0;
    case (state)
      vwgb_pkg::ST_CLEAR: clr_run  = 1'b1;
      vwgb_pkg::ST_IDLE:  in_stall = 1'b0;
      vwgb_pkg::ST_DONE:  out_load = !out_valid || !out_stall;
      default: begin
        in_stall = 1'b1;
      end
    endcase
    accept = in_valid && !in_stall;
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cur_op == vwgb_pkg::OP_READ) begin
        next_x    <= 10'd0;
        read_data <= rd_in_range ? rd_data : 8'h00;
      end else begin
        next_x    <= 10'(pen) + 10'(width);
        read_data <= 8'h00;
      end
    end
  end

  // ---- checks ----
  `VWGB_ASSERT_NOW(a_port_clash, rd_en && wr_en, rd_addr != wr_addr, "store read/write clash")
  `VWGB_ASSERT_NOW(a_wb_state, wb_pend, (state == vwgb_pkg::ST_DRAW) || (state == vwgb_pkg::ST_DONE), "write-back outside a draw")
  `VWGB_ASSERT_NOW(a_result_src, $rose(out_valid), $past(state) == vwgb_pkg::ST_DONE, "result without finished item")
  `VWGB_ASSERT_NEXT(a_last_step, (state == vwgb_pkg::ST_DRAW) && (step == vwgb_pkg::STEP_LAST), wb_pend && (state == vwgb_pkg::ST_DONE), "last byte not written back")

endmodule

FILE: tb/glyph_line_pkg.sv
// ---------------------------------------------------------------------------
// glyph_line_pkg
// Beat type and the predicting line store for the glyph blitter bench: a
// byte-exact copy of the tile line, updated for each accepted beat, and a
// queue of the results that it implies.
// ---------------------------------------------------------------------------
package glyph_line_pkg;

  import vwgb_pkg::*;

  typedef struct packed {
    logic            op;
    logic [3:0]      width;
    logic [7:0][7:0] rows;   // rows[0] is the top row
    logic [8:0]      pen;
    logic [9:0]      addr;
  } glyph_beat_t;

  typedef struct packed {
    logic [9:0] next_x;
    logic [7:0] read_data;
  } glyph_result_t;

  localparam int REPORT_LIMIT = 10;

  class glyph_line_model;
    int unsigned   store_size;
    logic [7:0]    line_bytes[];
    glyph_result_t expected_results[$];
    int unsigned   compared;
    int unsigned   mismatches;

    function new(int unsigned line_tiles);
      store_size = line_tiles * TILE_BYTES;
      line_bytes = new[store_size];
      foreach (line_bytes[i]) line_bytes[i] = 8'h00;
      compared   = 0;
      mismatches = 0;
    endfunction

    // writes beyond the last tile fall off the line
    function void merge_byte(int unsigned a, logic [7:0] keep, logic [7:0] set);
      if (a < store_size) line_bytes[a] = (line_bytes[a] & keep) | set;
    endfunction

    // apply one accepted beat and queue the result it should produce
    function void take_item(glyph_beat_t b);
      glyph_result_t r;
      int unsigned   w;
      int unsigned   f;
      int unsigned   base;
      int unsigned   keep;
      int unsigned   rowv;
      int unsigned   sh;
      if (b.op == OP_READ) begin
        r.next_x    = '0;
        r.read_data = (b.addr < store_size) ? line_bytes[b.addr] : 8'h00;
      end else begin
        w    = (b.width > MAX_WIDTH) ? MAX_WIDTH : b.width;
        f    = F_BASE - w - b.pen[2:0];
        keep = ~(((32'd1 << w) - 1) << f);
        base = b.pen[8:3] * TILE_BYTES;
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          rowv = b.rows[i];
          sh   = rowv << f;   // bits above 15 are simply not used
          merge_byte(base + 2 * i, keep[15:8], sh[15:8]);
          merge_byte(base + 2 * i + TILE_BYTES, keep[7:0], sh[7:0]);
        end
        r.next_x    = 10'(b.pen + w);
        r.read_data = 8'h00;
      end
      expected_results.push_back(r);
    endfunction

    function void match_result(logic [9:0] nx, logic [7:0] rd);
      glyph_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: next_x %0d read_data %02h", nx, rd);
        return;
      end
      e = expected_results.pop_front();
      compared++;
      if (nx !== e.next_x || rd !== e.read_data) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on result %0d: next_x exp %0d got %0d, read_data exp %02h got %02h",
                   compared, e.next_x, nx, e.read_data, rd);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Bench for variable_width_glyph_blitter: directed glyphs at the edges of
// width, pen position and line end, then random text runs with read-back,
// stray reads and raw draws, under changing sender and receiver pacing.
// ---------------------------------------------------------------------------
module tb_top;

  import vwgb_pkg::*;
  import glyph_line_pkg::*;

  localparam int LINE_TILES  = 64;
  localparam int ITEMS       = 1550;
  localparam int PHASE_BEATS = 120;    // beats per pacing phase
  localparam int HOLD_AT     = 400;    // result count that triggers the long hold
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 50000;
  localparam int TAIL_CYCLES = 40;     // long enough to cover two draws

  typedef enum int {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_BOTH
  } idle_phase_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       operation   = OP_DRAW;
  logic [3:0] glyph_width = '0;
  logic [7:0] glyph_row_0 = '0;
  logic [7:0] glyph_row_1 = '0;
  logic [7:0] glyph_row_2 = '0;
  logic [7:0] glyph_row_3 = '0;
  logic [7:0] glyph_row_4 = '0;
  logic [7:0] glyph_row_5 = '0;
  logic [7:0] glyph_row_6 = '0;
  logic [7:0] glyph_row_7 = '0;
  logic [8:0] pen_x       = '0;
  logic [9:0] read_addr   = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [9:0] next_x;
  logic [7:0] read_data;

  glyph_line_model glyphs;
  idle_phase_t     idle_phase   = PH_STEADY;
  int unsigned     beats_sent   = 0;
  int unsigned     results_seen = 0;
  int unsigned     draws_sent   = 0;
  int unsigned     reads_sent   = 0;
  int unsigned     wide_draws   = 0;   // widths above eight
  int unsigned     edge_draws   = 0;   // glyph in the last tile
  bit              hold_done    = 1'b0;

  variable_width_glyph_blitter #(.LINE_TILES(LINE_TILES)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .glyph_width (glyph_width),
    .glyph_row_0 (glyph_row_0),
    .glyph_row_1 (glyph_row_1),
    .glyph_row_2 (glyph_row_2),
    .glyph_row_3 (glyph_row_3),
    .glyph_row_4 (glyph_row_4),
    .glyph_row_5 (glyph_row_5),
    .glyph_row_6 (glyph_row_6),
    .glyph_row_7 (glyph_row_7),
    .pen_x       (pen_x),
    .read_addr   (read_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_x      (next_x),
    .read_data   (read_data)
  );

  always #2 clk = ~clk;

  // Hard stop, well beyond the slowest sane run, including the store
  // sweep after reset.
  initial begin
    #2_000_000;
    $display("variable_width_glyph_blitter verification failed");
    $finish;
  end

  // ---- beat builders ------------------------------------------------------
  // Fields that the operation ignores still get random content, so every
  // input bit toggles whatever the mix of draws and reads.
  function automatic glyph_beat_t draw_beat(int w, int pen, logic [63:0] rows);
    glyph_beat_t b;
    b.op    = OP_DRAW;
    b.width = w[3:0];
    b.rows  = rows;
    b.pen   = pen[8:0];
    b.addr  = 10'($urandom_range(1023));
    return b;
  endfunction

  function automatic glyph_beat_t read_beat(int addr);
    glyph_beat_t b;
    b.op    = OP_READ;
    b.width = 4'($urandom_range(15));
    b.rows  = {$urandom(), $urandom()};
    b.pen   = 9'($urandom_range(511));
    b.addr  = addr[9:0];
    return b;
  endfunction

  // ---- sender -------------------------------------------------------------
  // Called at a rising edge. Optional gap first (valid low), then the beat
  // is held until it is taken. Valid is left high on return, so a
  // back-to-back beat never drops it within the same step.
  task automatic offer_beat(glyph_beat_t b);
    int gap_pct;
    case (idle_phase)
      PH_SENDER_GAPS: gap_pct = 58;
      PH_BOTH:        gap_pct = 14;
      default:        gap_pct = 0;
    endcase
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation   <= b.op;
    glyph_width <= b.width;
    glyph_row_0 <= b.rows[0];
    glyph_row_1 <= b.rows[1];
    glyph_row_2 <= b.rows[2];
    glyph_row_3 <= b.rows[3];
    glyph_row_4 <= b.rows[4];
    glyph_row_5 <= b.rows[5];
    glyph_row_6 <= b.rows[6];
    glyph_row_7 <= b.rows[7];
    pen_x       <= b.pen;
    read_addr   <= b.addr;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // beat taken at this edge
    glyphs.take_item(b);
    beats_sent++;
    if (b.op == OP_DRAW) begin
      draws_sent++;
      if (b.width > MAX_WIDTH) wide_draws++;
      if (b.pen[8:3] == LINE_TILES - 1) edge_draws++;
    end else begin
      reads_sent++;
    end
  endtask

  // ---- receiver -----------------------------------------------------------
  // Samples at each edge, then picks the stall for the next cycle. Once,
  // partway in, it holds off for a long stretch while the sender keeps
  // going, so the result register fills and the input backs up.
  initial begin
    int hold_left;
    int stall_pct;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
        glyphs.match_result(next_x, read_data);
        results_seen++;
      end
      case (idle_phase)
        PH_RECEIVER_STALLS: stall_pct = 58;
        PH_BOTH:            stall_pct = 14;
        default:            stall_pct = 0;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---- main sequence ------------------------------------------------------
  initial begin
    glyph_beat_t directed[$];
    logic [63:0] rows;
    int          pen;
    int          start_tile;
    int          span;
    int          addr;
    int          w;
    int          sat;
    int          roll;

    glyphs = new(LINE_TILES);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: cleared store, full and empty widths, sub-tile offsets,
    // widths that clamp to eight, glyph at the very end of the line (the
    // following tile is off the line), zero width with the row bits still
    // shifted into the high byte, shift overflow, plane-1 bytes untouched.
    directed.push_back(read_beat(0));
    directed.push_back(draw_beat(8, 0, {8{8'hFF}}));
    directed.push_back(read_beat(0));
    directed.push_back(read_beat(16));
    directed.push_back(draw_beat(1, 7, 64'h0101_0101_0101_0101));
    directed.push_back(draw_beat(0, 7, {8{8'hFF}}));
    directed.push_back(draw_beat(0, 0, {8{8'hFF}}));
    directed.push_back(read_beat(2));
    directed.push_back(read_beat(3));
    directed.push_back(draw_beat(9, 13, 64'h0123_4567_89AB_CDEF));
    directed.push_back(draw_beat(15, 100, {8{8'hA5}}));
    directed.push_back(draw_beat(12, 255, {8{8'h5A}}));
    directed.push_back(draw_beat(8, 511, {8{8'hFF}}));
    directed.push_back(draw_beat(8, 504, 64'h8040_2010_0804_0201));
    directed.push_back(draw_beat(5, 496, {8{8'h1F}}));
    directed.push_back(read_beat(1008));
    directed.push_back(read_beat(1022));
    directed.push_back(read_beat(1023));
    directed.push_back(read_beat(1000));
    directed.push_back(draw_beat(8, 0, 64'h0));
    directed.push_back(read_beat(0));
    directed.push_back(read_beat(17));
    directed.push_back(draw_beat(3, 258, {8{8'h07}}));
    directed.push_back(read_beat(512));
    foreach (directed[i]) offer_beat(directed[i]);

    // Random: mostly runs of glyphs set as text (pen carried on by the
    // clamped width) followed by read-back of the tiles they touched;
    // the rest stray reads and raw draws with any field value.
    while (beats_sent < ITEMS) begin
      idle_phase = idle_phase_t'((beats_sent / PHASE_BEATS) % 4);
      roll = $urandom_range(99);
      if (roll < 70) begin
        pen        = $urandom_range(511);
        start_tile = pen / 8;
        repeat ($urandom_range(8, 2)) begin
          if (pen <= 511) begin
            roll = $urandom_range(99);
            if (roll < 10)      w = 0;
            else if (roll < 20) w = $urandom_range(15, 9);
            else                w = $urandom_range(8, 1);
            sat  = (w > 8) ? 8 : w;
            rows = {$urandom(), $urandom()};
            // well-formed glyphs keep their rows inside the advance width
            if ($urandom_range(99) < 70)
              for (int i = 0; i < 8; i++) rows[8*i +: 8] &= 8'((1 << sat) - 1);
            offer_beat(draw_beat(w, pen, rows));
            pen += sat;
          end
        end
        span = ((pen > 511 ? 511 : pen) / 8 - start_tile + 2) * TILE_BYTES;
        repeat ($urandom_range(6, 2)) begin
          addr = start_tile * TILE_BYTES + $urandom_range(span - 1);
          offer_beat(read_beat(addr > 1023 ? 1023 : addr));
        end
      end else if (roll < 85) begin
        offer_beat(read_beat($urandom_range(1023)));
      end else begin
        offer_beat(draw_beat($urandom_range(15), $urandom_range(511),
                             {$urandom(), $urandom()}));
      end
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    roll = 0;
    while (glyphs.pending() != 0 && roll < DRAIN_LIMIT) begin
      @(posedge clk);
      roll++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d draws (%0d clamped widths, %0d in the last tile) and %0d reads",
             draws_sent, wide_draws, edge_draws, reads_sent);
    $display("%0d results compared, %0d mismatches, %0d still owed",
             glyphs.compared, glyphs.mismatches, glyphs.pending());
    if (glyphs.mismatches == 0 && glyphs.pending() == 0) begin
      $display("variable_width_glyph_blitter verification clean");
    end else begin
      $display("variable_width_glyph_blitter verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vwgb_pkg.sv
rtl/vwgb_ram.sv
rtl/variable_width_glyph_blitter.sv
tb/glyph_line_pkg.sv
tb/tb_top.sv
